/* src/arxc_pkg.sv */
// Shared types, constants and round functions for the ARX CBC cipher block.
`default_nettype none

package arxc_pkg;

  localparam int ROUNDS     = 48;
  localparam int RND_W      = 6;
  localparam int TAB_DEPTH  = 2 * ROUNDS;
  localparam int TAB_AW     = 7;
  localparam int IDX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);

  typedef logic [31:0]      word_t;
  typedef logic [3:0][31:0] blk_t;
  typedef logic [7:0][31:0] sched_t;

  typedef enum logic [1:0] {
    OP_EXPAND  = 2'd0,
    OP_RESTART = 2'd1,
    OP_BLOCK   = 2'd2,
    OP_RSVD    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0 = 3'd0,
    CFG_KEY1 = 3'd1,
    CFG_KEY2 = 3'd2,
    CFG_KEY3 = 3'd3,
    CFG_IVU  = 3'd4,
    CFG_IVL  = 3'd5,
    CFG_DIR  = 3'd6,
    CFG_NONE = 3'd7
  } cfg_idx_e;

  // Key schedule fill phases, in the order the tables are filled
  typedef enum logic [2:0] {
    PH_TKA = 3'd0,
    PH_TKB = 3'd1,
    PH_TAD = 3'd2,
    PH_RK  = 3'd3,
    PH_RAD = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_SWR,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    word_t      in_word0;
    word_t      in_word1;
    word_t      in_word2;
    word_t      in_word3;
  } in_item_t;

  typedef struct packed {
    word_t out_word0;
    word_t out_word1;
    word_t out_word2;
    word_t out_word3;
    logic  block_done;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic             cap_in;
    logic             ld_keys;
    logic             ld_iv;
    logic             rnd_en;
    logic             sched;
    logic             inv;
    logic [RND_W-1:0] rd_round;
    logic             wr_en;
    phase_e           phase;
    logic [IDX_W-1:0] idx;
    logic             out_ld;
    logic             out_blk;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dir;
    logic out_free;
  } sts_t;

  // Last write index of each fill phase
  function automatic logic [IDX_W-1:0] phase_last(phase_e ph);
    logic [IDX_W-1:0] v;
    v = '0;
    unique case (ph)
      PH_TKA:  v = IDX_W'(ROUNDS - 1);
      PH_TKB:  v = IDX_W'(ROUNDS - 1);
      PH_TAD:  v = IDX_W'(4 * ROUNDS - 1);
      PH_RK:   v = IDX_W'(2 * ROUNDS - 1);
      PH_RAD:  v = IDX_W'(4 * ROUNDS - 1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Table address: temporary schedule in the low half, working schedule above
  function automatic logic [TAB_AW-1:0] tab_addr(logic upper, logic [RND_W-1:0] r);
    logic [TAB_AW-1:0] base;
    base = upper ? TAB_AW'(ROUNDS) : '0;
    return base + TAB_AW'(r);
  endfunction

  function automatic blk_t fwd_round(blk_t w, word_t ka, word_t kb, blk_t ad);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    blk_t  o;
    a = w[0];
    b = w[1];
    c = w[2];
    d = w[3];
    a = {a[7:0], a[31:8]} + d;
    a = a ^ ka;
    b = {b[6:0], b[31:7]} + c;
    b = b ^ kb;
    c = {c[29:0], c[31:30]} ^ b;
    d = {d[28:0], d[31:29]} ^ a;
    a = a + b;
    b = b + a;
    o[0] = a + ad[0];
    o[1] = b + ad[1];
    o[2] = c + ad[2];
    o[3] = d + ad[3];
    return o;
  endfunction

  function automatic blk_t inv_round(blk_t w, word_t ka, word_t kb, blk_t ad);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t t;
    blk_t  o;
    a = w[0] - ad[0];
    b = w[1] - ad[1];
    c = w[2] - ad[2];
    d = w[3] - ad[3];
    b = b - a;
    a = a - b;
    t = d ^ a;
    d = {t[2:0], t[31:3]};
    t = c ^ b;
    c = {t[1:0], t[31:2]};
    b = b ^ kb;
    t = b - c;
    b = {t[24:0], t[31:25]};
    a = a ^ ka;
    t = a - d;
    a = {t[23:0], t[31:24]};
    o[0] = a;
    o[1] = b;
    o[2] = c;
    o[3] = d;
    return o;
  endfunction

endpackage

`default_nettype wire

/* src/arxc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module arxc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/arxc_ctrl.sv */
// Controller: sequences expand, restart and block items over the round datapath.
`default_nettype none

module arxc_ctrl
  import arxc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_opcode,
  output      logic       in_stall,
  input  wire sts_t       sts,
  output      cmd_t       cmd
);

  state_e           state_r, state_nxt;
  logic [RND_W-1:0] rc_r, rc_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  phase_e           phase_r, phase_nxt;
  logic             sched_r, sched_nxt;
  logic             inv_r, inv_nxt;
  logic             blk_r, blk_nxt;
  logic             accept;
  logic             run_last;
  logic             idx_last;
  logic [RND_W-1:0] cur_round;
  op_e              op;

  assign op        = op_e'(in_opcode);
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign run_last  = (rc_r == LAST_ROUND);
  assign idx_last  = (idx_r == phase_last(phase_r));
  assign cur_round = inv_r ? (LAST_ROUND - rc_r) : rc_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_EXPAND || op == OP_BLOCK) begin
            state_nxt = ST_PREP;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_PREP: state_nxt = ST_RUN;
      ST_RUN: begin
        if (run_last) begin
          state_nxt = sched_r ? ST_SWR : ST_FIN;
        end
      end
      ST_SWR: begin
        if (idx_last && phase_r == PH_RAD) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_PREP;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Counters and item mode
  always_comb begin
    rc_nxt    = rc_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    sched_nxt = sched_r;
    inv_nxt   = inv_r;
    blk_nxt   = blk_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sched_nxt = (op == OP_EXPAND);
          inv_nxt   = (op == OP_BLOCK) && sts.dir;
          blk_nxt   = (op == OP_BLOCK);
          idx_nxt   = '0;
          phase_nxt = PH_TKA;
        end
      end
      ST_PREP: rc_nxt = '0;
      ST_RUN: begin
        if (!run_last) begin
          rc_nxt = rc_r + RND_W'(1);
        end
      end
      ST_SWR: begin
        if (idx_last) begin
          idx_nxt = '0;
          if (phase_r != PH_RAD) begin
            phase_nxt = phase_e'(phase_r + 3'd1);
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.sched    = sched_r;
    cmd.inv      = inv_r;
    cmd.phase    = phase_r;
    cmd.idx      = idx_r;
    cmd.out_blk  = blk_r;
    cmd.rd_round = cur_round;
    unique case (state_r)
      ST_IDLE: begin
        cmd.cap_in  = accept && (op == OP_BLOCK);
        cmd.ld_keys = accept && (op == OP_EXPAND);
        cmd.ld_iv   = accept && (op == OP_RESTART);
      end
      ST_PREP: begin
        cmd.rd_round = inv_r ? LAST_ROUND : '0;
      end
      ST_RUN: begin
        cmd.rnd_en = 1'b1;
        if (!run_last) begin
          cmd.rd_round = inv_r ? (cur_round - RND_W'(1)) : (cur_round + RND_W'(1));
        end
      end
      ST_SWR: begin
        cmd.wr_en = 1'b1;
        cmd.ld_iv = idx_last && (phase_r == PH_RAD);
      end
      ST_FIN: begin
        cmd.out_ld = sts.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rc_r    <= '0;
      idx_r   <= '0;
      phase_r <= PH_TKA;
      sched_r <= 1'b0;
      inv_r   <= 1'b0;
      blk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rc_r    <= rc_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      sched_r <= sched_nxt;
      inv_r   <= inv_nxt;
      blk_r   <= blk_nxt;
    end
  end

  // Table writes only come from a key schedule
  a_wr_sched: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> sched_r && !inv_r)
    else $error("table write outside key schedule");

  // No result is loaded in the cycle after a block is taken
  a_blk_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_BLOCK) |=> !cmd.out_ld)
    else $error("block result loaded too early");

  // Schedule bookkeeping stays within its tables
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= phase_last(phase_r) && phase_r <= PH_RAD)
    else $error("schedule index out of range");

  // A result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free && state_r == ST_FIN)
    else $error("result loaded while output busy");

endmodule

`default_nettype wire

/* src/arxc_dp.sv */
// Datapath: config registers, round units, schedule tables, chain and result register.
`default_nettype none

module arxc_dp
  import arxc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire in_item_t              in_item,
  input  wire cmd_t                  cmd,
  output      sts_t                  sts,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      out_item_t             out_item
);

  logic [3:0][CFG_DATA_W-1:0] key_r;
  logic [1:0][CFG_DATA_W-1:0] iv_r;
  logic                       dir_r;
  blk_t                       chain_r, chain_nxt;
  blk_t                       blk_r, blk_nxt;
  blk_t                       sav_r, sav_nxt;
  sched_t                     sw_r, sw_nxt;
  out_item_t                  out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [RND_W-1:0]           cur_r_r;
  blk_t                       in_blk;
  blk_t                       iv_blk;
  word_t                      ka_rd, kb_rd;
  blk_t                       ad_rd;
  word_t                      ka_m, kb_m;
  blk_t                       ad_m;
  word_t                      wr_x;
  logic [TAB_AW-1:0]          rd_addr;
  logic                       ka_we, kb_we;
  logic [3:0]                 ad_we;
  logic [TAB_AW-1:0]          ka_wa, ad_wa;
  blk_t                       fwd_b, inv_b;
  blk_t                       out_b;

  assign in_blk = {in_item.in_word3, in_item.in_word2, in_item.in_word1, in_item.in_word0};
  assign iv_blk = {iv_r[1][31:0], iv_r[1][63:32], iv_r[0][31:0], iv_r[0][63:32]};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      iv_r  <= '0;
      dir_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_KEY0: key_r[0] <= cfg_wdata;
        CFG_KEY1: key_r[1] <= cfg_wdata;
        CFG_KEY2: key_r[2] <= cfg_wdata;
        CFG_KEY3: key_r[3] <= cfg_wdata;
        CFG_IVU:  iv_r[0]  <= cfg_wdata;
        CFG_IVL:  iv_r[1]  <= cfg_wdata;
        CFG_DIR:  dir_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Schedule tables: key a, key b and four addend lanes
  assign rd_addr = tab_addr(!cmd.sched, cmd.rd_round);

  always_comb begin
    ka_we = 1'b0;
    kb_we = 1'b0;
    ad_we = '0;
    ka_wa = '0;
    ad_wa = tab_addr(cmd.phase == PH_RAD, cmd.idx[7:2]);
    unique case (cmd.phase)
      PH_TKA: begin
        ka_we = cmd.wr_en;
        ka_wa = tab_addr(1'b0, cmd.idx[RND_W-1:0]);
      end
      PH_TKB: begin
        kb_we = cmd.wr_en;
        ka_wa = tab_addr(1'b0, cmd.idx[RND_W-1:0]);
      end
      PH_RK: begin
        ka_we = cmd.wr_en && !cmd.idx[0];
        kb_we = cmd.wr_en && cmd.idx[0];
        ka_wa = tab_addr(1'b1, cmd.idx[6:1]);
      end
      PH_TAD, PH_RAD: begin
        ad_we[cmd.idx[1:0]] = cmd.wr_en;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_x = '0;
    for (int i = 0; i < 8; i++) begin
      wr_x = wr_x ^ sw_r[i];
    end
  end

  arxc_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_ka_ram (
    .clk(clk), .wr_en(ka_we), .wr_addr(ka_wa), .wr_data(wr_x),
    .rd_addr(rd_addr), .rd_data(ka_rd)
  );

  arxc_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_kb_ram (
    .clk(clk), .wr_en(kb_we), .wr_addr(ka_wa), .wr_data(wr_x),
    .rd_addr(rd_addr), .rd_data(kb_rd)
  );

  for (genvar g = 0; g < 4; g++) begin : g_ad
    arxc_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_ad_ram (
      .clk(clk), .wr_en(ad_we[g]), .wr_addr(ad_wa), .wr_data(wr_x),
      .rd_addr(rd_addr), .rd_data(ad_rd[g])
    );
  end

  // Zero temporary entries not yet filled in this schedule
  always_comb begin
    ka_m = ka_rd;
    kb_m = kb_rd;
    ad_m = ad_rd;
    if (cmd.sched) begin
      if (!(cmd.phase != PH_TKA || IDX_W'(cur_r_r) < cmd.idx)) begin
        ka_m = '0;
      end
      if (!(cmd.phase == PH_TAD || cmd.phase == PH_RK || cmd.phase == PH_RAD ||
            (cmd.phase == PH_TKB && IDX_W'(cur_r_r) < cmd.idx))) begin
        kb_m = '0;
      end
      for (int i = 0; i < 4; i++) begin
        if (!(cmd.phase == PH_RK || cmd.phase == PH_RAD ||
              (cmd.phase == PH_TAD && {cur_r_r, 2'(i)} < cmd.idx))) begin
          ad_m[i] = '0;
        end
      end
    end
  end

  assign fwd_b = fwd_round(blk_r, ka_m, kb_m, ad_m);
  assign inv_b = inv_round(blk_r, ka_m, kb_m, ad_m);
  assign out_b = cmd.inv ? (blk_r ^ chain_r) : blk_r;

  // Working words, chain and result
  always_comb begin
    blk_nxt       = blk_r;
    sav_nxt       = sav_r;
    sw_nxt        = sw_r;
    chain_nxt     = chain_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.cap_in) begin
      blk_nxt = dir_r ? in_blk : (in_blk ^ chain_r);
      sav_nxt = in_blk;
    end else if (cmd.rnd_en && !cmd.sched) begin
      blk_nxt = cmd.inv ? inv_b : fwd_b;
    end
    if (cmd.ld_keys) begin
      for (int i = 0; i < 4; i++) begin
        sw_nxt[2*i]   = key_r[i][63:32];
        sw_nxt[2*i+1] = key_r[i][31:0];
      end
    end else if (cmd.rnd_en && cmd.sched) begin
      sw_nxt[3:0] = fwd_round(sw_r[3:0], ka_m, kb_m, ad_m);
      sw_nxt[7:4] = fwd_round(sw_r[7:4], ka_m, kb_m, ad_m);
    end
    if (cmd.ld_iv) begin
      chain_nxt = iv_blk;
    end else if (cmd.out_ld && cmd.out_blk) begin
      chain_nxt = cmd.inv ? sav_r : blk_r;
    end
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
      if (cmd.out_blk) begin
        out_nxt = '{out_word0: out_b[0], out_word1: out_b[1], out_word2: out_b[2],
                    out_word3: out_b[3], block_done: 1'b1};
      end else begin
        out_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r   <= blk_nxt;
    sav_r   <= sav_nxt;
    sw_r    <= sw_nxt;
    out_r   <= out_nxt;
    cur_r_r <= cmd.rd_round;
  end

  assign sts.dir      = dir_r;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_item     = out_r;

endmodule

`default_nettype wire

/* src/arx_block_cipher_cbc.sv */
// Top level of the 128-bit, 48-round ARX block cipher in CBC mode.
`default_nettype none

// Each accepted item gives exactly one result item. A block item reads its
// first round keys from the tables, runs 48 rounds at one round per cycle
// through its round unit, then loads its result once the output register is
// free. The next item is accepted the cycle after its result is loaded into
// the output register, so no new block is taken before the last result is
// loaded. An expand item runs 576 schedule steps, each a table read, 48
// rounds on both key halves in parallel and a table write. Restart and the
// unused opcode go straight to loading their result. Key and IV registers
// act only at the next expand or restart; direction is sampled when a block
// is accepted. A block before the first expand returns undefined data.
module arx_block_cipher_cbc
  import arxc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire in_item_t              in_data,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      out_item_t             out_data
);

  cmd_t cmd;
  sts_t sts;

  arxc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  arxc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_data)
  );

endmodule

`default_nettype wire

/* verif/tb_arx_block_cipher_cbc.sv */
// Self-checking testbench for the ARX block cipher in CBC mode.
`timescale 1ns / 100ps

module tb_arx_block_cipher_cbc;
  import arxc_pkg::*;

  localparam int          IDLE_LIMIT  = 120000;
  localparam int          LONG_HOLD   = 500;
  localparam int          DRAIN_WAIT  = 60;
  localparam logic [63:0] ONES64      = '1;

  // Cipher predictor and expected-result store
  class cbc_scoreboard;
    bit [63:0] regs[7];
    bit [31:0] tka[ROUNDS];
    bit [31:0] tkb[ROUNDS];
    bit [31:0] tad[4*ROUNDS];
    bit [31:0] rka[ROUNDS];
    bit [31:0] rkb[ROUNDS];
    bit [31:0] rad[4*ROUNDS];
    bit [31:0] kw[8];
    bit [31:0] chain[4];
    out_item_t expected[$];
    int        errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (chain[i]) chain[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, bit [63:0] val);
      if (idx == CFG_DIR) regs[idx] = {63'd0, val[0]};
      else if (idx != CFG_NONE) regs[idx] = val;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    static function bit [31:0] rotr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    static function bit [31:0] rotl(bit [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    // Forward rounds, keyed by the temporary or the working schedule
    function void encrypt(bit use_temp, inout bit [31:0] w[4]);
      bit [31:0] a, b, c, d, ka, kb;
      a = w[0]; b = w[1]; c = w[2]; d = w[3];
      for (int r = 0; r < ROUNDS; r++) begin
        ka = use_temp ? tka[r] : rka[r];
        kb = use_temp ? tkb[r] : rkb[r];
        a = (rotr(a, 8) + d) ^ ka;
        b = (rotr(b, 7) + c) ^ kb;
        c = rotl(c, 2) ^ b;
        d = rotl(d, 3) ^ a;
        a = a + b;
        b = b + a;
        a += use_temp ? tad[4*r]   : rad[4*r];
        b += use_temp ? tad[4*r+1] : rad[4*r+1];
        c += use_temp ? tad[4*r+2] : rad[4*r+2];
        d += use_temp ? tad[4*r+3] : rad[4*r+3];
      end
      w[0] = a; w[1] = b; w[2] = c; w[3] = d;
    endfunction

    function void decrypt(inout bit [31:0] w[4]);
      bit [31:0] a, b, c, d;
      a = w[0]; b = w[1]; c = w[2]; d = w[3];
      for (int r = ROUNDS - 1; r >= 0; r--) begin
        d -= rad[4*r+3];
        c -= rad[4*r+2];
        b -= rad[4*r+1];
        a -= rad[4*r];
        b -= a;
        a -= b;
        d = rotr(d ^ a, 3);
        c = rotr(c ^ b, 2);
        b = rotl((b ^ rkb[r]) - c, 7);
        a = rotl((a ^ rka[r]) - d, 8);
      end
      w[0] = a; w[1] = b; w[2] = c; w[3] = d;
    endfunction

    // Advance both key halves one step and fold all eight words
    function bit [31:0] key_step();
      bit [31:0] lo[4], hi[4], x;
      foreach (lo[i]) begin
        lo[i] = kw[i];
        hi[i] = kw[i+4];
      end
      encrypt(1'b1, lo);
      encrypt(1'b1, hi);
      x = '0;
      foreach (lo[i]) begin
        kw[i] = lo[i];
        kw[i+4] = hi[i];
        x ^= lo[i] ^ hi[i];
      end
      return x;
    endfunction

    function void reload_iv();
      chain[0] = regs[CFG_IVU][63:32];
      chain[1] = regs[CFG_IVU][31:0];
      chain[2] = regs[CFG_IVL][63:32];
      chain[3] = regs[CFG_IVL][31:0];
    endfunction

    function void expand();
      foreach (tka[i]) begin
        tka[i] = '0; tkb[i] = '0; rka[i] = '0; rkb[i] = '0;
      end
      foreach (tad[i]) begin
        tad[i] = '0; rad[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
        kw[2*i]   = regs[i][63:32];
        kw[2*i+1] = regs[i][31:0];
      end
      for (int r = 0; r < ROUNDS; r++) tka[r] = key_step();
      for (int r = 0; r < ROUNDS; r++) tkb[r] = key_step();
      for (int i = 0; i < 4 * ROUNDS; i++) tad[i] = key_step();
      for (int r = 0; r < ROUNDS; r++) begin
        rka[r] = key_step();
        rkb[r] = key_step();
      end
      for (int i = 0; i < 4 * ROUNDS; i++) rad[i] = key_step();
      reload_iv();
    endfunction

    // Note an accepted item and queue the result it causes
    function void note_input(in_item_t it);
      bit [31:0] w[4], saved[4];
      out_item_t res;
      res = '0;
      case (op_e'(it.opcode))
        OP_EXPAND:  expand();
        OP_RESTART: reload_iv();
        OP_BLOCK: begin
          w[0] = it.in_word0; w[1] = it.in_word1;
          w[2] = it.in_word2; w[3] = it.in_word3;
          saved = w;
          if (regs[CFG_DIR][0]) begin
            decrypt(w);
            foreach (w[i]) begin
              w[i] ^= chain[i];
              chain[i] = saved[i];
            end
          end else begin
            foreach (w[i]) w[i] ^= chain[i];
            encrypt(1'b0, w);
            chain = w;
          end
          res.out_word0 = w[0];
          res.out_word1 = w[1];
          res.out_word2 = w[2];
          res.out_word3 = w[3];
          res.block_done = 1'b1;
        end
        default: ;
      endcase
      expected.push_back(res);
    endfunction

    // Compare a result with the oldest expectation
    function void check(out_item_t got);
      out_item_t exp_item;
      if (expected.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, got);
        errors++;
        return;
      end
      exp_item = expected.pop_front();
      if (got.out_word0 !== exp_item.out_word0)
        $display("%0t: out_word0 expected %h actual %h", $time, exp_item.out_word0,
                 got.out_word0);
      if (got.out_word1 !== exp_item.out_word1)
        $display("%0t: out_word1 expected %h actual %h", $time, exp_item.out_word1,
                 got.out_word1);
      if (got.out_word2 !== exp_item.out_word2)
        $display("%0t: out_word2 expected %h actual %h", $time, exp_item.out_word2,
                 got.out_word2);
      if (got.out_word3 !== exp_item.out_word3)
        $display("%0t: out_word3 expected %h actual %h", $time, exp_item.out_word3,
                 got.out_word3);
      if (got.block_done !== exp_item.block_done)
        $display("%0t: block_done expected %b actual %b", $time, exp_item.block_done,
                 got.block_done);
      if (got !== exp_item) errors++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  cbc_scoreboard sb;
  bit            quiet;
  bit            long_hold_req;
  int            idle_cycles;

  arx_block_cipher_cbc i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus a long hold on request
  initial begin
    int left;
    left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        left = LONG_HOLD;
      end else if (left == 0 && !quiet && $urandom_range(0, 99) < 25) begin
        left = pick_gap();
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check results and watch for a stuck run
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check(out_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL arx_block_cipher_cbc");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(op_e op, bit [31:0] w0, bit [31:0] w1, bit [31:0] w2,
                           bit [31:0] w3);
    in_item_t it;
    int gap;
    it = '{opcode: op, in_word0: w0, in_word1: w1, in_word2: w2, in_word3: w3};
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_block(bit [31:0] w0, bit [31:0] w1, bit [31:0] w2, bit [31:0] w3);
    send_item(OP_BLOCK, w0, w1, w2, w3);
  endtask

  task automatic send_random_block();
    send_item(OP_BLOCK, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Drop valid and hold until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return ONES64;
    return {$urandom, $urandom};
  endfunction

  // Random item mix: mostly blocks, some restarts and unused opcodes
  task automatic send_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) send_random_block();
    else if (r < 95) send_item(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
    else send_item(OP_RSVD, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    long_hold_req = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme key and IV, encrypt
    cfg_write(CFG_KEY0, ONES64);
    cfg_write(CFG_KEY1, '0);
    cfg_write(CFG_KEY2, ONES64);
    cfg_write(CFG_KEY3, 64'h0123_4567_89ab_cdef);
    cfg_write(CFG_IVU, ONES64);
    cfg_write(CFG_IVL, ONES64);
    cfg_write(CFG_DIR, 64'd0);
    send_item(OP_EXPAND, '1, '1, '1, '1);
    send_block('0, '0, '0, '0);
    send_block('1, '1, '1, '1);
    send_item(OP_RSVD, '1, '0, '1, '0);
    send_item(OP_RESTART, '0, '1, '0, '1);
    send_block('0, '0, '0, '0);
    send_block(32'h8000_0000, 32'h0000_0001, '1, '0);
    drain();

    // Directed: decrypt, IV changes only at restart, unused register index
    cfg_write(CFG_DIR, ONES64);
    cfg_write(CFG_IVU, '0);
    cfg_write(CFG_IVL, '0);
    cfg_write(CFG_NONE, ONES64);
    send_block('1, '1, '1, '1);
    send_block('0, '0, '0, '0);
    send_item(OP_RESTART, '0, '0, '0, '0);
    send_block('0, '0, '0, '0);
    send_block('1, '1, '1, '1);
    send_item(OP_RSVD, '0, '0, '0, '0);
    drain();

    // Random phases: fresh key and expand, then sub-phases with new IV and direction
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      cfg_write(CFG_KEY0, pick_key());
      cfg_write(CFG_KEY1, pick_key());
      cfg_write(CFG_KEY2, pick_key());
      cfg_write(CFG_KEY3, pick_key());
      cfg_write(CFG_IVU, pick_key());
      cfg_write(CFG_IVL, pick_key());
      send_item(OP_EXPAND, $urandom, $urandom, $urandom, $urandom);
      for (int sub = 0; sub < 4; sub++) begin
        quiet = (sub == 2);
        if (ph == 0 && sub == 1) long_hold_req = 1'b1;
        for (int n = 0; n < 65; n++) send_random_item();
        drain();
        cfg_write(CFG_DIR, {63'd0, 1'($urandom_range(0, 1))});
        cfg_write(CFG_IVU, pick_key());
        cfg_write(CFG_IVL, pick_key());
        if ($urandom_range(0, 1)) send_item(OP_RESTART, '0, '0, '0, '0);
      end
      quiet = 1'b0;
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS arx_block_cipher_cbc");
    end else begin
      $display("FAIL arx_block_cipher_cbc");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/arxc_pkg.sv
src/arxc_ram.sv
src/arxc_ctrl.sv
src/arxc_dp.sv
src/arx_block_cipher_cbc.sv
verif/tb_arx_block_cipher_cbc.sv
